>>> rtl/cmcc_pkg.sv
// shared types and constants of the cascaded motor current controller
package cmcc_pkg;

    localparam int MOTOR_W = 2;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_VEL    = 2'd1;
    localparam logic [1:0] MODE_POS    = 2'd2;
    localparam logic [1:0] MODE_SEARCH = 2'd3;

    localparam logic [1:0] STG_IDLE = 2'd0;
    localparam logic [1:0] STG_UP   = 2'd1;
    localparam logic [1:0] STG_DOWN = 2'd2;
    localparam logic [1:0] STG_DONE = 2'd3;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_MASK = 3'd1;
    localparam logic [2:0] REG_KP   = 3'd2;
    localparam logic [2:0] REG_KI   = 3'd3;
    localparam logic [2:0] REG_PG   = 3'd4;

    localparam int INTEG_LIMIT  = 16667;
    localparam int DRIVE_LIMIT  = 15000;
    localparam int PERR_LIMIT   = 4000;
    localparam int VERR_LIMIT   = 1000;
    localparam int STALL_TICKS  = 100;
    localparam int SEARCH_SPEED = 100;
    // reciprocals for /100 (exact below 2^20) and /5 (exact below 2^18)
    localparam logic [20:0] RECIP_100 = 21'd1342178;
    localparam int          SHIFT_100 = 27;
    localparam logic [15:0] RECIP_5   = 16'd52429;
    localparam int          SHIFT_5   = 18;
    localparam int          QUO_LIMIT = 75000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  mask;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] pg;
        logic        restart;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic st_pos;
        logic st_div;
        logic st_err;
        logic st_mul;
        logic st_sum;
        logic st_quo;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> rtl/cmcc_in_if.sv
// input word channel
interface cmcc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         motor;
    logic signed [31:0] position;
    logic signed [15:0] velocity;
    logic signed [31:0] target_position;
    logic signed [15:0] target_velocity;

    modport source (output valid, motor, position, velocity, target_position,
                    target_velocity, input ready);
    modport sink (input valid, motor, position, velocity, target_position,
                  target_velocity, output ready);
endinterface

>>> rtl/cmcc_out_if.sv
// result word channel
interface cmcc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         motor_out;
    logic signed [14:0] drive_current;
    logic               windup_hit;
    logic [1:0]         search_stage;
    logic signed [15:0] limit_low;
    logic signed [15:0] limit_high;

    modport source (output valid, motor_out, drive_current, windup_hit, search_stage,
                    limit_low, limit_high, input ready);
    modport sink (input valid, motor_out, drive_current, windup_hit, search_stage,
                  limit_low, limit_high, output ready);
endinterface

>>> rtl/cmcc_regs.sv
// apb configuration registers
module cmcc_regs import cmcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [1:0]  r_mode;
    logic [3:0]  r_mask;
    logic [15:0] r_kp, r_ki, r_pg;
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HOLD;
            r_mask <= 4'd1;
            r_kp   <= 16'd3328;
            r_ki   <= 16'd1536;
            r_pg   <= 16'd3840;
        end else if (wr) begin
            unique case (idx)
                REG_MODE: r_mode <= pwdata[1:0];
                REG_MASK: r_mask <= pwdata[3:0];
                REG_KP:   r_kp   <= pwdata[15:0];
                REG_KI:   r_ki   <= pwdata[15:0];
                REG_PG:   r_pg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE: prdata = {30'd0, r_mode};
            REG_MASK: prdata = {28'd0, r_mask};
            REG_KP:   prdata = {16'd0, r_kp};
            REG_KI:   prdata = {16'd0, r_ki};
            REG_PG:   prdata = {16'd0, r_pg};
            default:  prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{mode: r_mode, mask: r_mask, kp: r_kp, ki: r_ki, pg: r_pg,
                     restart: wr && (idx == REG_MODE)};
endmodule

>>> rtl/cmcc_ctrl.sv
// control sequencer stepping one word through the datapath
module cmcc_ctrl import cmcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_POS  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_ERR  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_SUM  = 8'b0010_0000,
        S_QUO  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        n_state       = r_state;
        o_cmd.capture = o_in_ready && i_in_valid;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_POS;
            S_POS: begin o_cmd.st_pos = 1'b1; n_state = S_DIV; end
            S_DIV: begin o_cmd.st_div = 1'b1; n_state = S_ERR; end
            S_ERR: begin o_cmd.st_err = 1'b1; n_state = S_MUL; end
            S_MUL: begin o_cmd.st_mul = 1'b1; n_state = S_SUM; end
            S_SUM: begin o_cmd.st_sum = 1'b1; n_state = S_QUO; end
            S_QUO: begin o_cmd.st_quo = 1'b1; n_state = S_DONE; end
            S_DONE: begin
                // wait for the output register to free up
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free) else $error("commit without free slot");
    a_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_in_ready) else $error("ready while busy");
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_in_ready) else $error("not idle after commit");
`endif
endmodule

>>> rtl/cmcc_dp.sv
// datapath: error math, shared pi arithmetic, per-motor state and result register
module cmcc_dp import cmcc_pkg::*; #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    cmcc_in_if.sink   i_in,
    cmcc_out_if.source o_out
);
    logic [1:0]         r_motor;
    logic signed [31:0] r_pos, r_tpos;
    logic signed [15:0] r_vel, r_tvel;

    logic signed [15:0] r_integ [MOTOR_COUNT];
    logic signed [15:0] r_hold  [MOTOR_COUNT];
    logic [15:0]        r_low   [MOTOR_COUNT];
    logic [15:0]        r_high  [MOTOR_COUNT];
    logic [1:0]         r_stage [MOTOR_COUNT+1];
    logic [6:0]         r_stall;

    logic [27:0]        r_pmul;
    logic               r_pneg;
    logic [40:0]        r_pdiv;
    logic signed [16:0] r_verr;
    logic signed [17:0] r_sum;
    logic               r_hit;
    logic signed [37:0] r_p1;
    logic signed [38:0] r_p2;
    logic [16:0]        r_q;
    logic               r_dsat, r_dneg;
    logic [32:0]        r_qmul;

    logic               r_ovalid;
    logic [1:0]         r_omotor, r_ostage;
    logic signed [14:0] r_odrive;
    logic               r_ohit;
    logic [15:0]        r_olow, r_ohigh;

    logic               in_range, enabled, run;
    logic signed [15:0] cur_integ, cur_hold;
    logic [15:0]        cur_low, cur_high;
    logic [1:0]         cur_stage;

    assign in_range = int'(r_motor) < MOTOR_COUNT;
    assign enabled  = i_cfg.mask[r_motor];

    always_comb begin
        cur_integ = '0;
        cur_hold  = '0;
        cur_low   = '0;
        cur_high  = '0;
        cur_stage = STG_IDLE;
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            if (int'(r_motor) == k) begin
                cur_integ = r_integ[k];
                cur_hold  = r_hold[k];
                cur_low   = r_low[k];
                cur_high  = r_high[k];
                cur_stage = r_stage[k];
            end
        end
    end

    always_comb begin
        unique case (i_cfg.mode) inside
            MODE_VEL, MODE_POS: run = in_range && enabled;
            MODE_SEARCH: run = in_range && (cur_stage == STG_UP || cur_stage == STG_DOWN);
            default:     run = 1'b0;
        endcase
    end

    // position error, clamped, and velocity error
    logic signed [32:0] pdiff;
    logic [11:0]        pabs;
    logic               pneg;
    logic signed [14:0] tv;
    logic signed [15:0] tsel;
    logic signed [16:0] vdiff, verr;
    logic signed [17:0] sum_raw, sum_sat;
    logic               hit;

    assign pdiff = 33'(r_tpos) - 33'(r_pos);
    assign pneg  = pdiff[32];

    always_comb begin
        if (pdiff > 33'sd4000 || pdiff < -33'sd4000) pabs = 12'(PERR_LIMIT);
        else if (pneg) pabs = 12'(-pdiff);
        else           pabs = pdiff[11:0];

        tv = r_pneg ? -15'(r_pdiv[40:SHIFT_100]) : 15'(r_pdiv[40:SHIFT_100]);
        if (i_cfg.mode == MODE_SEARCH)
            tsel = (cur_stage == STG_UP) ? 16'(SEARCH_SPEED) : -16'(SEARCH_SPEED);
        else
            tsel = r_tvel;
        vdiff = 17'(tsel) - 17'(r_vel);
        if (i_cfg.mode == MODE_POS)         verr = 17'(tv) - 17'(r_vel);
        else if (vdiff > 17'sd1000)         verr = 17'(VERR_LIMIT);
        else if (vdiff < -17'sd1000)        verr = -17'(VERR_LIMIT);
        else                                verr = vdiff;

        sum_raw = 18'(cur_integ) + 18'(verr);
        hit     = 1'b0;
        sum_sat = sum_raw;
        if (sum_raw > 18'sd16667) begin
            sum_sat = 18'(INTEG_LIMIT);
            hit     = 1'b1;
        end else if (sum_raw < -18'sd16667) begin
            sum_sat = -18'(INTEG_LIMIT);
            hit     = 1'b1;
        end
    end

    // drive numerator, truncated magnitude over 512
    logic [19:0]        kp10;
    logic signed [38:0] num;
    logic [38:0]        nmag;
    logic [29:0]        q512;

    assign kp10 = {1'b0, i_cfg.kp, 3'd0} + {3'd0, i_cfg.kp, 1'b0};
    assign num  = 39'(r_p1) + r_p2;
    assign nmag = num[38] ? 39'(-num) : 39'(num);
    assign q512 = nmag[38:9];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_motor <= i_in.motor;
            r_pos   <= i_in.position;
            r_vel   <= i_in.velocity;
            r_tpos  <= i_in.target_position;
            r_tvel  <= i_in.target_velocity;
        end
        if (i_cmd.st_pos) begin
            r_pmul <= 28'(i_cfg.pg) * 28'(pabs);
            r_pneg <= pneg;
        end
        if (i_cmd.st_div) r_pdiv <= 41'(r_pmul[27:8]) * 41'(RECIP_100);
        if (i_cmd.st_err) begin
            r_verr <= verr;
            r_sum  <= sum_sat;
            r_hit  <= hit;
        end
        if (i_cmd.st_mul) begin
            r_p1 <= 38'($signed({1'b0, kp10})) * 38'(r_verr);
            r_p2 <= 39'($signed({1'b0, i_cfg.ki})) * 39'(r_sum);
        end
        if (i_cmd.st_sum) begin
            r_dsat <= q512 >= 30'(QUO_LIMIT);
            r_q    <= q512[16:0];
            r_dneg <= num[38];
        end
        if (i_cmd.st_quo) r_qmul <= 33'(r_q) * 33'(RECIP_5);
    end

    // commit of per-motor state
    logic signed [15:0] dmag, drive, new_hold;
    logic [6:0]         stall_inc, new_stall;
    logic [1:0]         new_stage;
    logic [15:0]        new_low, new_high;
    logic               stall_end, done_stage;

    assign dmag = r_dsat ? 16'(DRIVE_LIMIT) : 16'(r_qmul[32:SHIFT_5]);
    assign drive = r_dneg ? -dmag : dmag;
    assign stall_inc = r_stall + 7'd1;
    assign stall_end = r_hit && (stall_inc > 7'(STALL_TICKS));
    assign done_stage = in_range && (i_cfg.mode == MODE_SEARCH) && (cur_stage == STG_DONE);

    always_comb begin
        new_hold  = cur_hold;
        new_stall = r_stall;
        new_stage = cur_stage;
        new_low   = cur_low;
        new_high  = cur_high;
        if (run) begin
            new_hold = drive;
            if (i_cfg.mode == MODE_SEARCH) begin
                new_stall = r_hit ? stall_inc : 7'd0;
                if (stall_end) begin
                    new_stall = 7'd0;
                    if (cur_stage == STG_UP) begin
                        new_low   = r_pos[15:0];
                        new_stage = STG_DOWN;
                    end else begin
                        new_high  = r_pos[15:0];
                        new_stage = STG_DONE;
                    end
                end
            end
        end else if (done_stage) begin
            new_hold  = '0;
            new_stage = STG_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_integ[k] <= '0;
                r_hold[k]  <= '0;
                r_low[k]   <= '0;
                r_high[k]  <= '0;
            end
            for (int k = 0; k <= MOTOR_COUNT; k++) r_stage[k] <= (k == 0) ? STG_UP : STG_IDLE;
            r_stall <= '0;
        end else if (i_cfg.restart) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_low[k]  <= '0;
                r_high[k] <= '0;
            end
            for (int k = 0; k <= MOTOR_COUNT; k++) r_stage[k] <= (k == 0) ? STG_UP : STG_IDLE;
            r_stall <= '0;
        end else if (i_cmd.commit && in_range) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                if (int'(r_motor) == k) begin
                    if (run) r_integ[k] <= 16'(r_sum);
                    r_hold[k]  <= new_hold;
                    r_low[k]   <= new_low;
                    r_high[k]  <= new_high;
                    r_stage[k] <= new_stage;
                end
            end
            // search hands over to the next motor
            if (done_stage) begin
                for (int k = 1; k <= MOTOR_COUNT; k++)
                    if (int'(r_motor) + 1 == k) r_stage[k] <= STG_UP;
            end
            r_stall <= new_stall;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_omotor <= r_motor;
            r_odrive <= in_range ? new_hold[14:0] : '0;
            r_ohit   <= run && r_hit;
            r_ostage <= in_range ? new_stage : STG_IDLE;
            r_olow   <= in_range ? new_low : '0;
            r_ohigh  <= in_range ? new_high : '0;
        end
    end

    assign o_sts.out_free    = !r_ovalid || o_out.ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.motor_out    = r_omotor;
    assign o_out.drive_current = r_odrive;
    assign o_out.windup_hit   = r_ohit;
    assign o_out.search_stage = r_ostage;
    assign o_out.limit_low    = r_olow;
    assign o_out.limit_high   = r_ohigh;
endmodule

>>> rtl/cascaded_motor_current_controller_unit.sv
// top level of the cascaded motor current controller
// Each input word is one control tick for one motor; the block works on one word
// at a time. A word is taken and then steps through the datapath (position
// multiply, divide by reciprocal, error and integrator, the two gain multiplies,
// numerator sum, divide by five) and a commit step that writes its result to the
// output register. The next word is accepted while the previous result still
// waits in the output register; a result that is ready to commit while the
// previous one still waits holds the sequencer in its commit state. Gains and
// mode must be set over the apb port only while no word is in flight; the block
// itself does not enforce this.
module cascaded_motor_current_controller_unit import cmcc_pkg::*; #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cmcc_in_if.sink     i_in,
    cmcc_out_if.source  o_out
);
    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    cmcc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    cmcc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    cmcc_dp #(.MOTOR_COUNT(MOTOR_COUNT)) u_dp (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_cmd(cmd), .o_sts(sts),
        .i_in(i_in), .o_out(o_out)
    );
endmodule

>>> sim/tb_cmcc_if.sv
// interfaces of the controller testbench are those of the rtl; this file holds the scoreboard
package tb_cmcc_pkg;
    import cmcc_pkg::*;

    typedef struct packed {
        logic [1:0]         motor;
        logic signed [14:0] drive;
        logic               windup;
        logic [1:0]         stage;
        logic signed [15:0] lim_lo;
        logic signed [15:0] lim_hi;
    } t_result;

    class current_scoreboard;
        logic [1:0]  mode;
        logic [3:0]  mask;
        logic [15:0] kp, ki, pg;
        longint      integ[4];
        longint      drive_hold[4];
        logic [1:0]  stage[5];
        int          stall_cnt;
        logic [15:0] lo_store[4], hi_store[4];
        t_result     pending[$];

        function new();
            mode = MODE_HOLD; mask = 4'd1; kp = 16'd3328; ki = 16'd1536; pg = 16'd3840;
            foreach (integ[i]) begin
                integ[i] = 0;
                drive_hold[i] = 0;
            end
            restart();
        endfunction

        function void restart();
            foreach (stage[i]) stage[i] = STG_IDLE;
            stage[0] = STG_UP;
            stall_cnt = 0;
            foreach (lo_store[i]) begin
                lo_store[i] = '0;
                hi_store[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MODE: begin
                    mode = val[1:0];
                    restart();
                end
                REG_MASK: mask = val[3:0];
                REG_KP:   kp = val[15:0];
                REG_KI:   ki = val[15:0];
                REG_PG:   pg = val[15:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function bit pi_step(int m, longint verr);
            bit hit;
            longint sum, num;
            hit = 0;
            sum = integ[m] + verr;
            if (sum > INTEG_LIMIT) begin
                sum = INTEG_LIMIT;
                hit = 1;
            end
            if (sum < -INTEG_LIMIT) begin
                sum = -INTEG_LIMIT;
                hit = 1;
            end
            integ[m] = sum;
            num = 10 * longint'(kp) * verr + longint'(ki) * sum;
            drive_hold[m] = clip(num / 2560, DRIVE_LIMIT);
            return hit;
        endfunction

        function bit search_leg(int m, longint vel, longint tgt, logic [15:0] pos_lo,
                                bit upper, logic [1:0] next);
            bit hit;
            hit = pi_step(m, clip(tgt - vel, VERR_LIMIT));
            if (hit) begin
                stall_cnt++;
                if (stall_cnt > STALL_TICKS) begin
                    if (upper) hi_store[m] = pos_lo;
                    else lo_store[m] = pos_lo;
                    stage[m] = next;
                    stall_cnt = 0;
                end
            end else stall_cnt = 0;
            return hit;
        endfunction

        // predict the result word of one accepted input word
        function void note_tick(logic [1:0] motor, logic signed [31:0] pos,
                                logic signed [15:0] vel, logic signed [31:0] tpos,
                                logic signed [15:0] tvel);
            t_result r;
            bit hit;
            int m;
            longint perr, tv;
            hit = 0;
            m = motor;
            r = '0;
            r.motor = motor;
            if (m < 4) begin
                if (mode == MODE_VEL) begin
                    if (mask[m]) hit = pi_step(m, clip(longint'(tvel) - vel, VERR_LIMIT));
                end else if (mode == MODE_POS) begin
                    if (mask[m]) begin
                        perr = clip(longint'(tpos) - longint'(pos), PERR_LIMIT);
                        tv = (longint'(pg) * perr) / 25600;
                        hit = pi_step(m, tv - vel);
                    end
                end else if (mode == MODE_SEARCH) begin
                    case (stage[m])
                        STG_UP:   hit = search_leg(m, vel, SEARCH_SPEED, pos[15:0], 0, STG_DOWN);
                        STG_DOWN: hit = search_leg(m, vel, -SEARCH_SPEED, pos[15:0], 1,
                                                   STG_DONE);
                        STG_DONE: begin
                            stage[m + 1] = STG_UP;
                            stage[m] = STG_IDLE;
                            drive_hold[m] = 0;
                        end
                        default: ;
                    endcase
                end
                r.drive = drive_hold[m][14:0];
                r.windup = hit;
                r.stage = stage[m];
                r.lim_lo = lo_store[m];
                r.lim_hi = hi_store[m];
            end
            pending.push_back(r);
        endfunction

        // returns 1 on a missing or mismatching result word, else 0
        function int check_result(t_result got, output string msg);
            t_result e;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result word motor %0d", got.motor);
                return 1;
            end
            e = pending.pop_front();
            if (got !== e) begin
                msg = $sformatf("motor %0d/%0d drive %0d/%0d hit %0d/%0d stg %0d/%0d lo %0d/%0d hi %0d/%0d",
                    got.motor, e.motor, got.drive, e.drive, got.windup, e.windup,
                    got.stage, e.stage, got.lim_lo, e.lim_lo, got.lim_hi, e.lim_hi);
                return 1;
            end
            return 0;
        endfunction
    endclass
endpackage

>>> sim/tb.sv
// top of the cascaded motor current controller testbench
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmcc_pkg::*;
    import tb_cmcc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle = 0, recv_stall = 0;

    cmcc_in_if  in_ch();
    cmcc_out_if out_ch();
    current_scoreboard sb;

    cascaded_motor_current_controller_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.motor = '0;
        in_ch.position = '0;
        in_ch.velocity = '0;
        in_ch.target_position = '0;
        in_ch.target_velocity = '0;
        out_ch.ready = 0;
    end

    task automatic report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    // result side: random stalls, check every taken word
    always @(posedge i_clk) begin
        t_result got;
        string msg;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.motor_out, out_ch.drive_current, out_ch.windup_hit,
                        out_ch.search_stage, out_ch.limit_low, out_ch.limit_high};
                if (sb.check_result(got, msg) != 0) report(msg);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // setup phase, access phase, then idle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // valid stays up after the last word until drain drops it
    task automatic send_tick(logic [1:0] m, logic signed [31:0] pos, logic signed [15:0] vel,
                             logic signed [31:0] tpos, logic signed [15:0] tvel);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.motor <= m;
        in_ch.position <= pos;
        in_ch.velocity <= vel;
        in_ch.target_position <= tpos;
        in_ch.target_velocity <= tvel;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_tick(m, pos, vel, tpos, tvel);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_tick();
        logic signed [31:0] pos;
        logic signed [15:0] vel, tvel;
        logic signed [31:0] tpos;
        pos = $urandom;
        vel = 16'($urandom);
        tvel = 16'($urandom);
        if ($urandom_range(3) != 0) begin
            vel = 16'($signed($urandom_range(4000)) - 2000);
            tvel = 16'($signed($urandom_range(4000)) - 2000);
        end
        tpos = ($urandom_range(3) == 0) ? $urandom : pos + $signed($urandom_range(12000)) - 6000;
        send_tick(2'($urandom_range(3)), pos, vel, tpos, tvel);
    endtask

    // limit search: stall the searching motor with saturating velocity for the given number of ticks
    task automatic search_run(int ticks);
        int m;
        logic signed [15:0] vel;
        for (int k = 0; k < ticks; k++) begin
            m = 0;
            for (int j = 0; j < 4; j++) if (sb.stage[j] != STG_IDLE) m = j;
            vel = (sb.stage[m] == STG_DOWN) ? 16'sd1200 : -16'sd1200;
            if ($urandom_range(19) == 0) vel = 16'($urandom);
            if ($urandom_range(9) == 0) m = $urandom_range(3);
            send_tick(2'(m), $urandom, vel, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        int phase_idle[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{37, 37}};
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes in every mode
        for (int md = 0; md < 4; md++) begin
            reg_write(REG_MODE, md);
            reg_write(REG_MASK, 32'hf);
            send_tick(2'd0, 32'sh7fffffff, 16'sh7fff, 32'sh80000000, 16'sh8000);
            send_tick(2'd1, 32'sh80000000, 16'sh8000, 32'sh7fffffff, 16'sh7fff);
            send_tick(2'd2, 32'sd0, 16'sd0, 32'sd0, 16'sd0);
            send_tick(2'd3, -32'sd1, -16'sd1, 32'sd5, 16'sd500);
            send_tick(2'd3, 32'sh55555555, 16'sh5555, 32'shaaaaaaaa, 16'shaaaa);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            send_idle = phase_idle[ph % 4][0];
            recv_stall = phase_idle[ph % 4][1];
            drain();
            case (ph)
                0: begin
                    reg_write(REG_KP, 32'hffff);
                    reg_write(REG_KI, 32'hffff);
                    reg_write(REG_PG, 32'hffff);
                end
                1: begin
                    reg_write(REG_KP, 32'd0);
                    reg_write(REG_KI, 32'd0);
                    reg_write(REG_PG, 32'd0);
                end
                default: begin
                    reg_write(REG_KP, $urandom);
                    reg_write(REG_KI, $urandom_range(4000));
                    reg_write(REG_PG, $urandom);
                end
            endcase
            reg_write(REG_MASK, $urandom_range(15));
            reg_write(REG_MODE, ph % 4);
            if (ph % 4 == MODE_SEARCH) search_run(500);
            else for (int k = 0; k < 100; k++) random_tick();
        end
        // sender holds off until all results are in, then one more word
        drain();
        send_tick(2'd0, 32'sd1, 16'sd2, 32'sd3, 16'sd4);
        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
